### hdl/touch_event_frame_decoder_unit_macros.svh
// Assertion macros shared by the touch event frame decoder modules
`ifndef TOUCH_EVENT_FRAME_DECODER_UNIT_MACROS_SVH
`define TOUCH_EVENT_FRAME_DECODER_UNIT_MACROS_SVH

// Check a consequence in the same cycle as its cause
`define TEFD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause
`define TEFD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/tefd_pkg.sv
// Shared types, codes and constants of the touch event frame decoder
`default_nettype none

package tefd_pkg;

    // Field widths
    localparam int TYPE_W      = 16;
    localparam int CODE_W      = 16;
    localparam int VAL_W       = 32;
    localparam int CFG_W       = 16;
    localparam int FS_W        = 2;
    localparam int OUT_TDATA_W = 104;

    // Scaling arithmetic widths
    localparam int MAG_W  = 32;
    localparam int DISP_W = 16;
    localparam int DEN_W  = 16;
    localparam int NUM_W  = MAG_W + DISP_W;

    // Configuration port
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 3;

    // Event types and codes
    localparam logic [TYPE_W-1:0] EVT_SYN = 16'd0;
    localparam logic [TYPE_W-1:0] EVT_KEY = 16'd1;
    localparam logic [TYPE_W-1:0] EVT_ABS = 16'd3;

    localparam logic [CODE_W-1:0] CODE_X        = 16'd0;
    localparam logic [CODE_W-1:0] CODE_Y        = 16'd1;
    localparam logic [CODE_W-1:0] CODE_PRESSURE = 16'd24;
    localparam logic [CODE_W-1:0] CODE_TOUCH    = 16'd330;

    // Touch key values
    localparam logic [VAL_W-1:0] KEY_PRESSED  = 32'd1;
    localparam logic [VAL_W-1:0] KEY_RELEASED = 32'd0;

    // Frame states
    localparam logic [FS_W-1:0] FS_NONE = 2'd0;
    localparam logic [FS_W-1:0] FS_DOWN = 2'd1;
    localparam logic [FS_W-1:0] FS_UP   = 2'd2;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_RAW_X_LOW      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_RAW_X_HIGH     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_RAW_Y_LOW      = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RAW_Y_HIGH     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_PANEL_WIDTH    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DISPLAY_WIDTH  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_DISPLAY_HEIGHT = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SCALING_ON     = 3'd7;

    // Register reset values
    localparam logic [CFG_W-1:0] RST_RAW_X_LOW      = 16'd0;
    localparam logic [CFG_W-1:0] RST_RAW_X_HIGH     = 16'd4095;
    localparam logic [CFG_W-1:0] RST_RAW_Y_LOW      = 16'd0;
    localparam logic [CFG_W-1:0] RST_RAW_Y_HIGH     = 16'd4095;
    localparam logic [CFG_W-1:0] RST_PANEL_WIDTH    = 16'd4095;
    localparam logic [CFG_W-1:0] RST_DISPLAY_WIDTH  = 16'd800;
    localparam logic [CFG_W-1:0] RST_DISPLAY_HEIGHT = 16'd480;
    localparam logic             RST_SCALING_ON     = 1'b1;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_MUL,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_STORE,
        ST_EMIT
    } state_t;

    // Axis under scaling
    typedef enum logic {
        AX_X,
        AX_Y
    } axis_t;

    // Configuration registers
    typedef struct packed {
        logic [CFG_W-1:0] raw_x_low;
        logic [CFG_W-1:0] raw_x_high;
        logic [CFG_W-1:0] raw_y_low;
        logic [CFG_W-1:0] raw_y_high;
        logic [CFG_W-1:0] panel_width;
        logic [CFG_W-1:0] display_width;
        logic [CFG_W-1:0] display_height;
        logic             scaling_on;
    } cfg_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic  ready;
        logic  take;
        logic  setup;
        logic  mul;
        logic  div_start;
        logic  store;
        logic  commit;
        axis_t axis;
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic is_sync;
        logic need_x;
        logic need_y;
        logic div_done;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

### hdl/tefd_div.sv
// Restoring unsigned divider, one quotient bit per cycle
`default_nettype none

module tefd_div #(
    parameter int NUM_W = tefd_pkg::NUM_W,
    parameter int DEN_W = tefd_pkg::DEN_W
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] dividend,
    input  wire logic [DEN_W-1:0] divisor,
    output logic      [NUM_W-1:0] quotient,
    output logic                  done
);

    localparam int CNT_W = $clog2(NUM_W + 1);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(NUM_W - 1);

    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [DEN_W:0]   rem_shift;
    logic [DEN_W:0]   rem_diff;
    logic             fits;

    // Trial subtract of the divisor from the shifted remainder
    always_comb begin
        rem_shift = {rem_reg, quo_reg[NUM_W-1]};
        rem_diff  = rem_shift - {1'b0, den_reg};
        fits      = (rem_shift >= {1'b0, den_reg});
    end

    // Load on start, then shift one bit in per cycle
    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            den_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            quo_next = {quo_reg[NUM_W-2:0], fits};
            rem_next = fits ? rem_diff[DEN_W-1:0] : rem_shift[DEN_W-1:0];
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == LAST_STEP) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

`default_nettype wire

### hdl/tefd_dp.sv
// Datapath: frame capture, held coordinates, scaling and result register
`default_nettype none
`include "touch_event_frame_decoder_unit_macros.svh"

module tefd_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire tefd_pkg::cfg_t                cfg,
    input  wire tefd_pkg::cmd_t                cmd,
    output tefd_pkg::sts_t                     sts,
    input  wire logic [tefd_pkg::TYPE_W-1:0]   in_type,
    input  wire logic [tefd_pkg::CODE_W-1:0]   in_code,
    input  wire logic [tefd_pkg::VAL_W-1:0]    in_value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [tefd_pkg::FS_W-1:0]          out_state,
    output logic [tefd_pkg::VAL_W-1:0]         out_x,
    output logic [tefd_pkg::VAL_W-1:0]         out_y,
    output logic [tefd_pkg::VAL_W-1:0]         out_pressure
);

    localparam int VAL_W  = tefd_pkg::VAL_W;
    localparam int FS_W   = tefd_pkg::FS_W;
    localparam int MAG_W  = tefd_pkg::MAG_W;
    localparam int DISP_W = tefd_pkg::DISP_W;
    localparam int DEN_W  = tefd_pkg::DEN_W;
    localparam int NUM_W  = tefd_pkg::NUM_W;
    localparam int CFG_W  = tefd_pkg::CFG_W;
    localparam int XW     = VAL_W + 1;
    localparam int DW     = VAL_W + 2;

    localparam logic [VAL_W-1:0] INT_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] INT_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [NUM_W-1:0] Q_POS_LIMIT = NUM_W'(INT_MAX);
    localparam logic [NUM_W-1:0] Q_NEG_LIMIT = NUM_W'(INT_MIN);

    // Frame and held state
    logic [FS_W-1:0]  pend_state_reg, pend_state_next;
    logic [XW-1:0]    pend_x_reg, pend_x_next;
    logic             x_seen_reg, x_seen_next;
    logic [VAL_W-1:0] pend_y_reg, pend_y_next;
    logic             y_seen_reg, y_seen_next;
    logic [VAL_W-1:0] held_x_reg, held_x_next;
    logic [VAL_W-1:0] held_y_reg, held_y_next;
    logic [VAL_W-1:0] held_p_reg, held_p_next;

    // Scaling operands and results
    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic              neg_reg, neg_next;
    logic [DISP_W-1:0] disp_reg, disp_next;
    logic [DEN_W-1:0]  den_mag_reg, den_mag_next;
    logic [NUM_W-1:0]  prod_reg, prod_next;
    logic [VAL_W-1:0]  res_x_reg, res_x_next;
    logic [VAL_W-1:0]  res_y_reg, res_y_next;

    // Result register
    logic             out_valid_reg, out_valid_next;
    logic [FS_W-1:0]  out_state_reg, out_state_next;
    logic [VAL_W-1:0] out_x_reg, out_x_next;
    logic [VAL_W-1:0] out_y_reg, out_y_next;
    logic [VAL_W-1:0] out_p_reg, out_p_next;

    logic signed [DW-1:0] sel_v, sel_lo, diff, diff_abs;
    logic signed [DEN_W:0] den, den_abs;
    logic [CFG_W-1:0]      sel_hi;
    logic [NUM_W-1:0]      quotient;
    logic                  div_done;
    logic [VAL_W-1:0]      q_sat;
    logic [VAL_W-1:0]      x_raw_sat;
    logic                  x_flat, y_flat;

    tefd_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (prod_reg),
        .divisor  (den_mag_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    // Flat calibration on an axis gives zero when scaling is on
    assign x_flat = (cfg.raw_x_high == cfg.raw_x_low);
    assign y_flat = (cfg.raw_y_high == cfg.raw_y_low);

    // Status to the controller
    always_comb begin
        sts.is_sync  = (in_type == tefd_pkg::EVT_SYN);
        sts.need_x   = (pend_state_reg != tefd_pkg::FS_UP) && cfg.scaling_on
                       && x_seen_reg && !x_flat;
        sts.need_y   = (pend_state_reg != tefd_pkg::FS_UP) && cfg.scaling_on
                       && y_seen_reg && !y_flat;
        sts.div_done = div_done;
        sts.out_free = !out_valid_reg || out_ready;
    end

    // Select axis operands and take signed offset and span apart
    always_comb begin
        if (cmd.axis == tefd_pkg::AX_X) begin
            sel_v     = {pend_x_reg[XW-1], pend_x_reg};
            sel_lo    = DW'(cfg.raw_x_low);
            sel_hi    = cfg.raw_x_high;
            disp_next = cfg.display_width;
        end else begin
            sel_v     = {{2{pend_y_reg[VAL_W-1]}}, pend_y_reg};
            sel_lo    = DW'(cfg.raw_y_low);
            sel_hi    = cfg.raw_y_high;
            disp_next = cfg.display_height;
        end
        diff     = sel_v - sel_lo;
        diff_abs = diff[DW-1] ? -diff : diff;
        den      = $signed({1'b0, sel_hi}) - $signed({1'b0, sel_lo[CFG_W-1:0]});
        den_abs  = den[DEN_W] ? -den : den;
        mag_next     = diff_abs[MAG_W-1:0];
        den_mag_next = den_abs[DEN_W-1:0];
        neg_next     = diff[DW-1] ^ den[DEN_W];
    end

    // Multiply offset magnitude by the display size
    assign prod_next = NUM_W'(mag_reg) * NUM_W'(disp_reg);

    // Apply sign and saturate the quotient
    always_comb begin
        if (neg_reg) begin
            q_sat = (quotient > Q_NEG_LIMIT) ? INT_MIN : (-quotient[VAL_W-1:0]);
        end else begin
            q_sat = (quotient > Q_POS_LIMIT) ? INT_MAX : quotient[VAL_W-1:0];
        end
    end

    // Saturate the mirrored X when passed unscaled
    always_comb begin
        if (pend_x_reg[XW-1] != pend_x_reg[XW-2]) begin
            x_raw_sat = pend_x_reg[XW-1] ? INT_MIN : INT_MAX;
        end else begin
            x_raw_sat = pend_x_reg[VAL_W-1:0];
        end
    end

    // Capture events, store scaled values, close the frame
    always_comb begin
        pend_state_next = pend_state_reg;
        pend_x_next     = pend_x_reg;
        x_seen_next     = x_seen_reg;
        pend_y_next     = pend_y_reg;
        y_seen_next     = y_seen_reg;
        held_x_next     = held_x_reg;
        held_y_next     = held_y_reg;
        held_p_next     = held_p_reg;
        res_x_next      = res_x_reg;
        res_y_next      = res_y_reg;
        out_state_next  = out_state_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_p_next      = out_p_reg;
        out_valid_next  = out_valid_reg;

        if (out_ready) begin
            out_valid_next = 1'b0;
        end

        // Gather one event into the frame
        if (cmd.take) begin
            if (in_type == tefd_pkg::EVT_KEY && in_code == tefd_pkg::CODE_TOUCH) begin
                if (in_value == tefd_pkg::KEY_PRESSED) begin
                    pend_state_next = tefd_pkg::FS_DOWN;
                end else if (in_value == tefd_pkg::KEY_RELEASED) begin
                    pend_state_next = tefd_pkg::FS_UP;
                end
            end else if (in_type == tefd_pkg::EVT_ABS) begin
                if (in_code == tefd_pkg::CODE_X) begin
                    pend_x_next = XW'(cfg.panel_width) - {in_value[VAL_W-1], in_value};
                    x_seen_next = 1'b1;
                end else if (in_code == tefd_pkg::CODE_Y) begin
                    pend_y_next = in_value;
                    y_seen_next = 1'b1;
                end else if (in_code == tefd_pkg::CODE_PRESSURE) begin
                    held_p_next = in_value;
                end
            end
        end

        // Keep the finished quotient for its axis
        if (cmd.store) begin
            if (cmd.axis == tefd_pkg::AX_X) begin
                res_x_next = q_sat;
            end else begin
                res_y_next = q_sat;
            end
        end

        // Update held coordinates, load the result, clear the frame
        if (cmd.commit) begin
            if (pend_state_reg != tefd_pkg::FS_UP) begin
                if (x_seen_reg) begin
                    if (cfg.scaling_on) begin
                        held_x_next = x_flat ? '0 : res_x_reg;
                    end else begin
                        held_x_next = x_raw_sat;
                    end
                end
                if (y_seen_reg) begin
                    if (cfg.scaling_on) begin
                        held_y_next = y_flat ? '0 : res_y_reg;
                    end else begin
                        held_y_next = pend_y_reg;
                    end
                end
            end
            out_state_next  = pend_state_reg;
            out_x_next      = held_x_next;
            out_y_next      = held_y_next;
            out_p_next      = held_p_reg;
            out_valid_next  = 1'b1;
            pend_state_next = tefd_pkg::FS_NONE;
            pend_x_next     = '0;
            x_seen_next     = 1'b0;
            pend_y_next     = '0;
            y_seen_next     = 1'b0;
        end
    end

    // Architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_state_reg <= tefd_pkg::FS_NONE;
            pend_x_reg     <= '0;
            x_seen_reg     <= 1'b0;
            pend_y_reg     <= '0;
            y_seen_reg     <= 1'b0;
            held_x_reg     <= '0;
            held_y_reg     <= '0;
            held_p_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            pend_state_reg <= pend_state_next;
            pend_x_reg     <= pend_x_next;
            x_seen_reg     <= x_seen_next;
            pend_y_reg     <= pend_y_next;
            y_seen_reg     <= y_seen_next;
            held_x_reg     <= held_x_next;
            held_y_reg     <= held_y_next;
            held_p_reg     <= held_p_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Working and payload registers
    always_ff @(posedge aclk) begin
        if (cmd.setup) begin
            mag_reg     <= mag_next;
            neg_reg     <= neg_next;
            disp_reg    <= disp_next;
            den_mag_reg <= den_mag_next;
        end
        if (cmd.mul) begin
            prod_reg <= prod_next;
        end
        res_x_reg     <= res_x_next;
        res_y_reg     <= res_y_next;
        out_state_reg <= out_state_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_p_reg     <= out_p_next;
    end

    assign out_valid    = out_valid_reg;
    assign out_state    = out_state_reg;
    assign out_x        = out_x_reg;
    assign out_y        = out_y_reg;
    assign out_pressure = out_p_reg;

    `TEFD_ASSERT_NEXT(a_commit_clears_frame, aclk, aresetn, cmd.commit,
        (!x_seen_reg && !y_seen_reg && pend_state_reg == tefd_pkg::FS_NONE && out_valid_reg),
        "frame not cleared or result not posted after commit")

endmodule

`default_nettype wire

### hdl/tefd_ctrl.sv
// Controller: sequences capture, per-axis scaling and result posting
`default_nettype none
`include "touch_event_frame_decoder_unit_macros.svh"

module tefd_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    input  wire tefd_pkg::sts_t sts,
    output tefd_pkg::cmd_t      cmd
);

    tefd_pkg::state_t state_reg, state_next;
    tefd_pkg::axis_t  axis_reg, axis_next;

    // Next state and axis
    always_comb begin
        state_next = state_reg;
        axis_next  = axis_reg;
        unique case (state_reg)
            tefd_pkg::ST_IDLE: begin
                if (in_valid && sts.is_sync) begin
                    if (sts.need_x) begin
                        state_next = tefd_pkg::ST_SETUP;
                        axis_next  = tefd_pkg::AX_X;
                    end else if (sts.need_y) begin
                        state_next = tefd_pkg::ST_SETUP;
                        axis_next  = tefd_pkg::AX_Y;
                    end else begin
                        state_next = tefd_pkg::ST_EMIT;
                    end
                end
            end
            tefd_pkg::ST_SETUP:    state_next = tefd_pkg::ST_MUL;
            tefd_pkg::ST_MUL:      state_next = tefd_pkg::ST_DIV_LOAD;
            tefd_pkg::ST_DIV_LOAD: state_next = tefd_pkg::ST_DIV_RUN;
            tefd_pkg::ST_DIV_RUN: begin
                if (sts.div_done) begin
                    state_next = tefd_pkg::ST_STORE;
                end
            end
            tefd_pkg::ST_STORE: begin
                if (axis_reg == tefd_pkg::AX_X && sts.need_y) begin
                    state_next = tefd_pkg::ST_SETUP;
                    axis_next  = tefd_pkg::AX_Y;
                end else begin
                    state_next = tefd_pkg::ST_EMIT;
                end
            end
            tefd_pkg::ST_EMIT: begin
                if (sts.out_free) begin
                    state_next = tefd_pkg::ST_IDLE;
                end
            end
            default: state_next = tefd_pkg::ST_IDLE;
        endcase
    end

    // Commands to the datapath
    always_comb begin
        cmd.ready     = (state_reg == tefd_pkg::ST_IDLE);
        cmd.take      = (state_reg == tefd_pkg::ST_IDLE) && in_valid;
        cmd.setup     = (state_reg == tefd_pkg::ST_SETUP);
        cmd.mul       = (state_reg == tefd_pkg::ST_MUL);
        cmd.div_start = (state_reg == tefd_pkg::ST_DIV_LOAD);
        cmd.store     = (state_reg == tefd_pkg::ST_STORE);
        cmd.commit    = (state_reg == tefd_pkg::ST_EMIT) && sts.out_free;
        cmd.axis      = axis_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tefd_pkg::ST_IDLE;
            axis_reg  <= tefd_pkg::AX_X;
        end else begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    `TEFD_ASSERT_NEXT(a_sync_no_scale_emits, aclk, aresetn,
        (cmd.take && sts.is_sync && !sts.need_x && !sts.need_y),
        (state_reg == tefd_pkg::ST_EMIT),
        "sync with nothing to scale did not go straight to emit")

    `TEFD_ASSERT_NEXT(a_x_then_y, aclk, aresetn,
        (state_reg == tefd_pkg::ST_STORE && axis_reg == tefd_pkg::AX_X && sts.need_y),
        (state_reg == tefd_pkg::ST_SETUP && axis_reg == tefd_pkg::AX_Y),
        "Y scaling not started after X")

    `TEFD_ASSERT_NOW(a_setup_only_when_needed, aclk, aresetn,
        (state_reg == tefd_pkg::ST_SETUP),
        ((axis_reg == tefd_pkg::AX_X && sts.need_x) || (axis_reg == tefd_pkg::AX_Y && sts.need_y)),
        "scaling started on an axis that needs none")

endmodule

`default_nettype wire

### hdl/touch_event_frame_decoder_unit.sv
// Top level: touch event frame decoder with calibration scaling
//
//  Port group  Dir  Handshake        Payload
//  s_          in   tvalid/tready    tuser: ev_type, ev_code; tdata: ev_value
//  m_          out  tvalid/tready    tdata: frame_state, pos_x, pos_y, pressure_out
//  APB         in   psel/penable     8 registers at byte address 4*index
//
//  Key, axis and unknown events leave the controller idle. A sync runs setup,
//  multiply, divider load, 48-step divider run and store per scaled axis, then
//  emit; X and Y share the divider. s_tready is low while a sync is worked on;
//  a result waits in the output register, and the next sync holds in emit while
//  that register is full and m_tready is low. aresetn is synchronous and active
//  low; it restores register defaults and clears the frame and held coordinates.
`default_nettype none

module touch_event_frame_decoder_unit (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // Input items
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [tefd_pkg::VAL_W-1:0]          s_tdata,   // [31:0] ev_value
    // [15:0] ev_type, [31:16] ev_code
    input  wire logic [tefd_pkg::TYPE_W+tefd_pkg::CODE_W-1:0] s_tuser,
    // Result items
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // [1:0] frame_state, [33:2] pos_x, [65:34] pos_y, [97:66] pressure_out, rest zero
    output logic [tefd_pkg::OUT_TDATA_W-1:0]         m_tdata,
    // Configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [tefd_pkg::PADDR_W-1:0]        paddr,
    input  wire logic [tefd_pkg::PDATA_W-1:0]        pwdata,
    output logic [tefd_pkg::PDATA_W-1:0]             prdata,
    output logic                                     pready
);

    localparam int TYPE_W  = tefd_pkg::TYPE_W;
    localparam int CODE_W  = tefd_pkg::CODE_W;
    localparam int VAL_W   = tefd_pkg::VAL_W;
    localparam int FS_W    = tefd_pkg::FS_W;
    localparam int CFG_W   = tefd_pkg::CFG_W;
    localparam int PDATA_W = tefd_pkg::PDATA_W;
    localparam int PAD_W   = tefd_pkg::OUT_TDATA_W - FS_W - 3 * VAL_W;

    tefd_pkg::cfg_t cfg_reg, cfg_next;
    tefd_pkg::cmd_t cmd;
    tefd_pkg::sts_t sts;

    logic [tefd_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           cfg_wr;
    logic [FS_W-1:0]                out_state;
    logic [VAL_W-1:0]               out_x, out_y, out_p;

    assign reg_idx = paddr[tefd_pkg::PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    // Register writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr) begin
            unique case (reg_idx)
                tefd_pkg::REG_RAW_X_LOW:      cfg_next.raw_x_low      = pwdata[CFG_W-1:0];
                tefd_pkg::REG_RAW_X_HIGH:     cfg_next.raw_x_high     = pwdata[CFG_W-1:0];
                tefd_pkg::REG_RAW_Y_LOW:      cfg_next.raw_y_low      = pwdata[CFG_W-1:0];
                tefd_pkg::REG_RAW_Y_HIGH:     cfg_next.raw_y_high     = pwdata[CFG_W-1:0];
                tefd_pkg::REG_PANEL_WIDTH:    cfg_next.panel_width    = pwdata[CFG_W-1:0];
                tefd_pkg::REG_DISPLAY_WIDTH:  cfg_next.display_width  = pwdata[CFG_W-1:0];
                tefd_pkg::REG_DISPLAY_HEIGHT: cfg_next.display_height = pwdata[CFG_W-1:0];
                tefd_pkg::REG_SCALING_ON:     cfg_next.scaling_on     = pwdata[0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    // Register reads
    always_comb begin
        unique case (reg_idx)
            tefd_pkg::REG_RAW_X_LOW:      prdata = PDATA_W'(cfg_reg.raw_x_low);
            tefd_pkg::REG_RAW_X_HIGH:     prdata = PDATA_W'(cfg_reg.raw_x_high);
            tefd_pkg::REG_RAW_Y_LOW:      prdata = PDATA_W'(cfg_reg.raw_y_low);
            tefd_pkg::REG_RAW_Y_HIGH:     prdata = PDATA_W'(cfg_reg.raw_y_high);
            tefd_pkg::REG_PANEL_WIDTH:    prdata = PDATA_W'(cfg_reg.panel_width);
            tefd_pkg::REG_DISPLAY_WIDTH:  prdata = PDATA_W'(cfg_reg.display_width);
            tefd_pkg::REG_DISPLAY_HEIGHT: prdata = PDATA_W'(cfg_reg.display_height);
            tefd_pkg::REG_SCALING_ON:     prdata = PDATA_W'(cfg_reg.scaling_on);
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.raw_x_low      <= tefd_pkg::RST_RAW_X_LOW;
            cfg_reg.raw_x_high     <= tefd_pkg::RST_RAW_X_HIGH;
            cfg_reg.raw_y_low      <= tefd_pkg::RST_RAW_Y_LOW;
            cfg_reg.raw_y_high     <= tefd_pkg::RST_RAW_Y_HIGH;
            cfg_reg.panel_width    <= tefd_pkg::RST_PANEL_WIDTH;
            cfg_reg.display_width  <= tefd_pkg::RST_DISPLAY_WIDTH;
            cfg_reg.display_height <= tefd_pkg::RST_DISPLAY_HEIGHT;
            cfg_reg.scaling_on     <= tefd_pkg::RST_SCALING_ON;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    tefd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    tefd_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .cmd          (cmd),
        .sts          (sts),
        .in_type      (s_tuser[TYPE_W-1:0]),
        .in_code      (s_tuser[TYPE_W+CODE_W-1:TYPE_W]),
        .in_value     (s_tdata),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_state    (out_state),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_pressure (out_p)
    );

    assign s_tready = cmd.ready;
    assign m_tdata  = {{PAD_W{1'b0}}, out_p, out_y, out_x, out_state};

endmodule

`default_nettype wire
